FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; all checks are clocked on i_clk and
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FPSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define FPSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FPSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/fpsa_pkg.sv
`default_nettype none

package fpsa_pkg;

    localparam int unsigned NEED_W = 21;      // pages for a 32-bit byte size
    localparam int unsigned OUT_FRAME_W = 20;
    localparam int unsigned CNT_W = 20;
    localparam logic [CNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NORUN = 2'd3;

    typedef struct packed {
        logic              hit;
        logic              restart;
        logic [NEED_W-1:0] run_next;
    } t_step_res;

    function automatic logic [CNT_W-1:0] count_add(logic [CNT_W-1:0] c,
                                                   logic [NEED_W-1:0] n);
        logic [NEED_W:0] s;
        s = (NEED_W+1)'(c) + (NEED_W+1)'(n);
        if (s >= (NEED_W+1)'(COUNT_MAX)) begin
            return COUNT_MAX;
        end
        return s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] count_dec(logic [CNT_W-1:0] c);
        if (c == '0) begin
            return c;
        end
        return c - CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fpsa_stack_mem.sv
`default_nettype none

module fpsa_stack_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 20,
    parameter int unsigned AW    = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/fpsa_run_step.sv
`default_nettype none

// One step of the run search: does this entry extend the run by one page?
module fpsa_run_step #(
    parameter int unsigned FRAME_BITS = 20
) (
    input  wire logic [FRAME_BITS-1:0]       i_entry,
    input  wire logic [FRAME_BITS-1:0]       i_prev,
    input  wire logic                        i_have_prev,
    input  wire logic [fpsa_pkg::NEED_W-1:0] i_run,
    input  wire logic [fpsa_pkg::NEED_W-1:0] i_need,
    output fpsa_pkg::t_step_res              o_res
);

    logic contig;
    logic [fpsa_pkg::NEED_W-1:0] run_next;

    // extra top bit so the highest frame never chains into frame 0
    assign contig = i_have_prev &&
        ({1'b0, i_entry} == ({1'b0, i_prev} + (FRAME_BITS+1)'(1)));

    assign run_next = contig ? (i_run + fpsa_pkg::NEED_W'(1)) : fpsa_pkg::NEED_W'(1);

    assign o_res.hit      = (run_next == i_need);
    assign o_res.restart  = !contig;
    assign o_res.run_next = run_next;

endmodule

`default_nettype wire

FILE: hw/rtl/free_page_stack_allocator_unit.sv
// Sequencing: free, unused kind and failures found at once finish from idle; single-page
//   allocate passes S_POP; run allocate scans in S_SCAN and closes the gap in S_COPY.
// Throughput: one request at a time; ready only while idle. Scan and gap close run
//   one stack entry per cycle through the single stack memory read port.
// Reset: synchronous active low; clears fill, allocated counter, sequencer and
//   output valid. Stack memory is not cleared; only entries below the fill are read.
`default_nettype none
`include "assert_macros.svh"

module free_page_stack_allocator_unit #(
    parameter int unsigned STACK_DEPTH = 4096,
    parameter int unsigned FRAME_BITS  = 20
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [55:0] i_s_tdata,   // [19:0] freed_frame, [51:20] run_bytes, rest zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [55:0] o_m_tdata,   // [19:0] frame, [39:20] allocated_pages,
                                          // [52:40] free_count, rest zero
    output logic      [1:0]  o_m_tuser    // [1:0] status
);

    localparam int unsigned AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned FILLW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned NW    = fpsa_pkg::NEED_W;
    localparam int unsigned CW    = fpsa_pkg::CNT_W;
    localparam int unsigned OFW   = fpsa_pkg::OUT_FRAME_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_SCAN = 5'b00100,
        S_COPY = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [FILLW-1:0]      r_fill, n_fill;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_first, n_first;
    logic [FRAME_BITS-1:0] r_first_val, n_first_val;
    logic [FRAME_BITS-1:0] r_prev, n_prev;
    logic                  r_have_prev, n_have_prev;
    logic [NW-1:0]         r_run, n_run;
    logic [NW-1:0]         r_need, n_need;
    logic [FRAME_BITS-1:0] r_got, n_got;
    logic [FILLW-1:0]      r_src, n_src;
    logic [AW-1:0]         r_dst, n_dst;
    logic                  r_cp_pend, n_cp_pend;
    logic [OFW-1:0]        r_res_frame, n_res_frame;
    logic [1:0]            r_res_status, n_res_status;

    logic                  r_out_valid, n_out_valid;
    logic [OFW-1:0]        r_out_frame;
    logic [1:0]            r_out_status;
    logic [CW-1:0]         r_out_pages;
    logic [12:0]           r_out_fill;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [FRAME_BITS-1:0] mem_wdata, mem_rdata;

    fpsa_pkg::t_step_res   step;

    logic                  acc, out_free, fin, ld;
    logic [OFW-1:0]        fin_frame, ld_frame;
    logic [1:0]            fin_status, ld_status;
    logic [1:0]            kind;
    logic [31:0]           run_bytes;
    logic [NW-1:0]         need;
    logic [63:0]           freed_wide, rd_wide, got_wide, fill_wide;
    logic [AW-1:0]         hit_first;
    logic [FRAME_BITS-1:0] hit_val;

    fpsa_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (FRAME_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fpsa_run_step #(
        .FRAME_BITS (FRAME_BITS)
    ) u_step (
        .i_entry     (mem_rdata),
        .i_prev      (r_prev),
        .i_have_prev (r_have_prev),
        .i_run       (r_run),
        .i_need      (r_need),
        .o_res       (step)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    assign kind       = i_s_tuser;
    assign run_bytes  = i_s_tdata[51:20];
    assign need       = NW'(run_bytes[31:12]) + NW'(|run_bytes[11:0]);
    assign freed_wide = 64'(i_s_tdata[19:0]);
    assign rd_wide    = 64'(mem_rdata);
    assign got_wide   = 64'(r_got);
    assign hit_first  = step.restart ? r_idx : r_first;
    assign hit_val    = step.restart ? mem_rdata : r_first_val;

    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_count      = r_count;
        n_idx        = r_idx;
        n_first      = r_first;
        n_first_val  = r_first_val;
        n_prev       = r_prev;
        n_have_prev  = r_have_prev;
        n_run        = r_run;
        n_need       = r_need;
        n_got        = r_got;
        n_src        = r_src;
        n_dst        = r_dst;
        n_cp_pend    = r_cp_pend;
        n_res_frame  = r_res_frame;
        n_res_status = r_res_status;

        mem_we     = 1'b0;
        mem_waddr  = r_fill[AW-1:0];
        mem_wdata  = freed_wide[FRAME_BITS-1:0];
        mem_raddr  = AW'(r_fill - FILLW'(1));

        fin        = 1'b0;
        fin_frame  = '0;
        fin_status = fpsa_pkg::ST_OK;
        ld         = 1'b0;
        ld_frame   = r_res_frame;
        ld_status  = r_res_status;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (kind)
                        fpsa_pkg::KIND_ALLOC: begin
                            if (r_fill == '0) begin
                                fin        = 1'b1;
                                fin_status = fpsa_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        fpsa_pkg::KIND_FREE: begin
                            fin = 1'b1;
                            if (r_fill >= FILLW'(STACK_DEPTH)) begin
                                fin_status = fpsa_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_fill  = r_fill + FILLW'(1);
                                n_count = fpsa_pkg::count_dec(r_count);
                            end
                        end
                        fpsa_pkg::KIND_RUN: begin
                            if (r_fill == '0) begin
                                fin        = 1'b1;
                                fin_status = fpsa_pkg::ST_EMPTY;
                            end else if (need == '0 || 32'(need) > 32'(r_fill)) begin
                                fin        = 1'b1;
                                fin_status = fpsa_pkg::ST_NORUN;
                            end else begin
                                // top entry read is already under way
                                n_state     = S_SCAN;
                                n_idx       = AW'(r_fill - FILLW'(1));
                                n_have_prev = 1'b0;
                                n_run       = '0;
                                n_need      = need;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                fin       = 1'b1;
                fin_frame = rd_wide[OFW-1:0];
                n_fill    = r_fill - FILLW'(1);
                n_count   = fpsa_pkg::count_add(r_count, NW'(1));
            end
            S_SCAN: begin
                // mem_rdata holds entry r_idx; fetch the one below
                mem_raddr = r_idx - AW'(1);
                if (step.hit) begin
                    n_got     = hit_val;
                    n_dst     = r_idx;
                    n_src     = FILLW'(hit_first) + FILLW'(1);
                    n_cp_pend = 1'b0;
                    n_state   = S_COPY;
                end else begin
                    n_prev      = mem_rdata;
                    n_have_prev = 1'b1;
                    n_run       = step.run_next;
                    if (step.restart) begin
                        n_first     = r_idx;
                        n_first_val = mem_rdata;
                    end
                    if (r_idx == '0) begin
                        fin        = 1'b1;
                        fin_status = fpsa_pkg::ST_NORUN;
                    end else begin
                        n_idx = r_idx - AW'(1);
                    end
                end
            end
            S_COPY: begin
                // read from src, write the previous read to dst next cycle
                mem_raddr = r_src[AW-1:0];
                mem_waddr = r_dst;
                mem_wdata = mem_rdata;
                if (r_cp_pend) begin
                    mem_we = 1'b1;
                    n_dst  = r_dst + AW'(1);
                end
                if (r_src < r_fill) begin
                    n_src     = r_src + FILLW'(1);
                    n_cp_pend = 1'b1;
                end else begin
                    n_cp_pend = 1'b0;
                    if (!r_cp_pend) begin
                        fin       = 1'b1;
                        fin_frame = got_wide[OFW-1:0];
                        n_fill    = r_fill - FILLW'(r_need);
                        n_count   = fpsa_pkg::count_add(r_count, r_need);
                    end
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    ld      = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            if (out_free) begin
                ld        = 1'b1;
                ld_frame  = fin_frame;
                ld_status = fin_status;
                n_state   = S_IDLE;
            end else begin
                n_res_frame  = fin_frame;
                n_res_status = fin_status;
                n_state      = S_WAIT;
            end
        end

        n_out_valid = r_out_valid && !i_m_tready;
        if (ld) begin
            n_out_valid = 1'b1;
        end
    end

    assign fill_wide = 64'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_first      <= n_first;
        r_first_val  <= n_first_val;
        r_prev       <= n_prev;
        r_have_prev  <= n_have_prev;
        r_run        <= n_run;
        r_need       <= n_need;
        r_got        <= n_got;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_cp_pend    <= n_cp_pend;
        r_res_frame  <= n_res_frame;
        r_res_status <= n_res_status;
        if (ld) begin
            r_out_frame  <= ld_frame;
            r_out_status <= ld_status;
            r_out_pages  <= n_count;
            r_out_fill   <= fill_wide[12:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_fill, r_out_pages, r_out_frame};
    assign o_m_tuser  = r_out_status;

    `FPSA_ASSERT_NEXT(a_free_push,
        acc && kind == fpsa_pkg::KIND_FREE && r_fill < FILLW'(STACK_DEPTH),
        32'(r_fill) == 32'($past(r_fill)) + 32'd1,
        "free request did not grow the stack by one")
    `FPSA_ASSERT_NEXT(a_pop_drop,
        r_state == S_POP,
        32'(r_fill) + 32'd1 == 32'($past(r_fill)),
        "single-page allocate did not shrink the stack by one")
    `FPSA_ASSERT_IMPL(a_copy_order,
        r_state == S_COPY,
        32'(r_dst) < 32'(r_src),
        "gap close write overtook its read")
    `FPSA_ASSERT(a_fill_bound,
        32'(r_fill) <= 32'(STACK_DEPTH),
        "stack fill beyond depth")

endmodule

`default_nettype wire

FILE: tb/fpsa_tb_pkg.sv
`default_nettype none

package fpsa_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STACK_SLOTS = 4096;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [19:0] frame;
        logic [1:0]  status;
        logic [19:0] pages;
        logic [12:0] held;
    } t_page_reply;

    class t_page_scoreboard;
        logic [19:0] frames [STACK_SLOTS];
        int unsigned fill;
        logic [19:0] pages_out;
        t_page_reply replies [$];
        int unsigned faults;

        function new();
            fill      = 0;
            pages_out = '0;
            faults    = 0;
        endfunction

        function int unsigned pending();
            return replies.size();
        endfunction

        function int unsigned fill_level();
            return fill;
        endfunction

        // saturating raise of the allocated-page count
        function void add_pages(int unsigned n);
            int unsigned room;
            room = 32'(fpsa_pkg::COUNT_MAX - pages_out);
            if (n >= room) begin
                pages_out = fpsa_pkg::COUNT_MAX;
            end else begin
                pages_out = pages_out + 20'(n);
            end
        endfunction

        // top-down search for frames rising by one as the index falls
        function logic [1:0] carve_run(input logic [31:0] bytes,
                                       output logic [19:0] first_frame);
            int unsigned need, run, first, i, dst, src;
            logic [19:0] prev;
            first_frame = '0;
            need = (bytes >> 12) + ((bytes[11:0] != 12'd0) ? 1 : 0);
            if (fill == 0) begin
                return fpsa_pkg::ST_EMPTY;
            end
            run   = 0;
            first = 0;
            prev  = '0;
            for (int k = int'(fill); k > 0; k--) begin
                i = k - 1;
                // 21-bit compare so the top frame never chains into frame 0
                if (k != int'(fill) && {1'b0, frames[i]} == {1'b0, prev} + 21'd1) begin
                    run++;
                end else begin
                    run   = 1;
                    first = i;
                end
                prev = frames[i];
                if (run == need) begin
                    first_frame = frames[first];
                    dst = i;
                    src = first + 1;
                    while (src < fill) begin
                        frames[dst] = frames[src];
                        dst++;
                        src++;
                    end
                    fill -= need;
                    add_pages(need);
                    return fpsa_pkg::ST_OK;
                end
            end
            return fpsa_pkg::ST_NORUN;
        endfunction

        function void note_request(logic [1:0] kind, logic [19:0] freed, logic [31:0] bytes);
            t_page_reply r;
            r.frame  = '0;
            r.status = fpsa_pkg::ST_OK;
            case (kind)
                fpsa_pkg::KIND_ALLOC: begin
                    if (fill == 0) begin
                        r.status = fpsa_pkg::ST_EMPTY;
                    end else begin
                        fill--;
                        r.frame = frames[fill];
                        add_pages(1);
                    end
                end
                fpsa_pkg::KIND_FREE: begin
                    if (fill >= STACK_SLOTS) begin
                        r.status = fpsa_pkg::ST_FULL;
                    end else begin
                        frames[fill] = freed;
                        fill++;
                        if (pages_out != '0) begin
                            pages_out = pages_out - 20'd1;
                        end
                    end
                end
                fpsa_pkg::KIND_RUN: begin
                    r.status = carve_run(bytes, r.frame);
                end
                default: ;
            endcase
            r.pages = pages_out;
            r.held  = 13'(fill);
            replies.push_back(r);
        endfunction

        function void field_ok(string name, logic [19:0] want, logic [19:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want, got);
                faults++;
            end
        endfunction

        function void check_reply(logic [19:0] frame, logic [1:0] status,
                                  logic [19:0] pages, logic [12:0] held);
            t_page_reply e;
            if (replies.size() == 0) begin
                $display("%0t: reply with nothing outstanding, expected none got frame %0h",
                         $time, frame);
                faults++;
                return;
            end
            e = replies.pop_front();
            field_ok("frame", e.frame, frame);
            field_ok("status", 20'(e.status), 20'(status));
            field_ok("allocated_pages", e.pages, pages);
            field_ok("free_count", 20'(e.held), 20'(held));
        endfunction
    endclass

endpackage

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_TARGET = 1700;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [55:0] i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;

    fpsa_tb_pkg::t_page_scoreboard sb = new();

    int unsigned sent        = 0;
    int unsigned cycles      = 0;
    bit          calm        = 1'b0;
    bit          squeeze_req = 1'b0;

    free_page_stack_allocator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_request(i_s_tuser, i_s_tdata[19:0], i_s_tdata[51:20]);
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_reply(o_m_tdata[19:0], o_m_tuser, o_m_tdata[39:20], o_m_tdata[52:40]);
            end
        end
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin : receiver
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                hold_left   = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b1;
            end else begin
                stall_left = idle_span();
                i_m_tready <= 1'b0;
            end
        end
    end

    task automatic offer_request(logic [1:0] kind, logic [19:0] freed, logic [31:0] bytes);
        int unsigned gap;
        gap = calm ? 0 : idle_span();
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, bytes, freed};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        if (kind != fpsa_tb_pkg::KIND_UNUSED) begin
            sent++;
        end
    endtask

    task automatic push_frame(logic [19:0] f);
        offer_request(fpsa_pkg::KIND_FREE, f, 32'($urandom));
    endtask

    task automatic pop_frame();
        offer_request(fpsa_pkg::KIND_ALLOC, 20'($urandom), 32'($urandom));
    endtask

    task automatic claim_bytes(logic [31:0] bytes);
        offer_request(fpsa_pkg::KIND_RUN, 20'($urandom), bytes);
    endtask

    // random byte count that rounds up to exactly this many pages
    task automatic claim_pages(int unsigned pages);
        claim_bytes(32'((pages - 1) * 4096 + $urandom_range(1, 4096)));
    endtask

    task automatic wait_settled();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic directed_cases();
        pop_frame();
        claim_bytes(32'd0);                      // empty reported before size
        offer_request(fpsa_tb_pkg::KIND_UNUSED, 20'hFFFFF, 32'hFFFFFFFF);
        push_frame(20'h00000);                   // counter already at zero
        push_frame(20'hFFFFF);
        claim_bytes(32'd8192);                   // top frame then frame 0: no chain
        claim_bytes(32'd0);
        claim_bytes(32'hFFFFFFFF);
        claim_bytes(32'd1);
        push_frame(20'h12345);
        push_frame(20'h12344);
        claim_bytes(32'd8192);
        push_frame(20'd5);
        push_frame(20'd4);
        push_frame(20'd3);
        push_frame(20'd100);
        claim_bytes(32'd12288);                  // run under an odd frame, gap closed
        claim_bytes(32'd12289);
        claim_bytes(32'd4097);
        pop_frame();
        pop_frame();
        pop_frame();
        offer_request(fpsa_tb_pkg::KIND_UNUSED, 20'h0, 32'h0);
        wait_settled();
    endtask

    task automatic run_segment();
        int unsigned len, base, noise_at;
        len      = $urandom_range(1, 12);
        base     = ($urandom_range(0, 9) == 0) ? $urandom_range(20'hFFFF0, 20'hFFFFF)
                                                : $urandom_range(0, 20'hFFFFF);
        noise_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
        // pushed high to low, so the run rises from the top downwards
        for (int j = int'(len) - 1; j >= 0; j--) begin
            push_frame(20'(base + j));
            if (j == int'(noise_at)) begin
                push_frame(20'($urandom));
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            push_frame(20'($urandom));
        end
        claim_pages($urandom_range(1, len + 1));
        if ($urandom_range(0, 3) == 0) begin
            pop_frame();
        end
    endtask

    task automatic random_mix();
        int unsigned choice;
        while (sent < ITEM_TARGET + 25) begin
            choice = $urandom_range(0, 99);
            calm   = ($urandom_range(0, 9) == 0);
            if (sb.fill_level() > 160) begin
                repeat ($urandom_range(20, 60)) pop_frame();
            end else if (choice < 50) begin
                run_segment();
            end else if (choice < 62) begin
                pop_frame();
            end else if (choice < 74) begin
                push_frame(20'($urandom));
            end else if (choice < 86) begin
                claim_bytes(32'($urandom));
            end else if (choice < 92) begin
                claim_pages($urandom_range(1, 4));
            end else if (choice < 95) begin
                offer_request(fpsa_tb_pkg::KIND_UNUSED, 20'($urandom), 32'($urandom));
            end else if (choice < 98) begin
                wait_settled();
            end else begin
                squeeze_req = 1'b1;
                repeat (6) run_segment();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_cases();
        // long receiver hold while requests keep coming
        squeeze_req = 1'b1;
        repeat (4) run_segment();
        wait_settled();
        random_mix();
        wait_settled();
        repeat (20) @(posedge i_clk);
        if (sb.faults == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
